### rtl/gcsp_pkg.sv
package gcsp_pkg;

    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_DIM_DEF      = 32;
    localparam int MAX_KERNEL_DEF   = 7;

    // request codes
    localparam logic [1:0] REQ_ACT   = 2'd0;
    localparam logic [1:0] REQ_WGT   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_IN_CH  = 3'd0;
    localparam logic [2:0] CFG_OUT_CH = 3'd1;
    localparam logic [2:0] CFG_GROUPS = 3'd2;
    localparam logic [2:0] CFG_IMG_H  = 3'd3;
    localparam logic [2:0] CFG_IMG_W  = 3'd4;
    localparam logic [2:0] CFG_KERN_H = 3'd5;
    localparam logic [2:0] CFG_KERN_W = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_IC,
        ST_DIV_OC,
        ST_DIV_G,
        ST_MUL1,
        ST_MUL2,
        ST_LOOP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DIV_IC,
        DIV_OC,
        DIV_G
    } t_div_sel;

    typedef struct packed {
        logic     act_we;
        logic     wgt_we;
        logic     query_load;
        logic     div_load;
        t_div_sel div_sel;
        logic     cap_icg;
        logic     cap_g;
        logic     mul1;
        logic     mul2;
        logic     tap;
        logic [2:0] r;
        logic [2:0] s;
        logic     c_last;
        logic     out_load;
        logic     out_bad;
    } t_cmd;

    typedef struct packed {
        logic       basic_ok;
        logic       div_done;
        logic       div_rem_zero;
        logic [4:0] icg;
        logic [2:0] kh;
        logic [2:0] kw;
    } t_stat;

endpackage

### rtl/gcsp_ctrl.sv
module gcsp_ctrl import gcsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  logic       i_out_stall,
    input  t_stat      i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_r, n_r;
    logic [2:0] r_s, n_s;
    logic [4:0] r_c, n_c;
    logic       r_drain, n_drain;
    logic       r_bad, n_bad;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_r         <= '0;
            r_s         <= '0;
            r_c         <= '0;
            r_drain     <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_r         <= n_r;
            r_s         <= n_s;
            r_c         <= n_c;
            r_drain     <= n_drain;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_r         = r_r;
        n_s         = r_s;
        n_c         = r_c;
        n_drain     = r_drain;
        n_bad       = r_bad;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        o_cmd.r     = r_r;
        o_cmd.s     = r_s;
        o_cmd.c_last = (r_c == i_stat.icg - 5'd1);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_ACT:   o_cmd.act_we = 1'b1;
                        REQ_WGT:   o_cmd.wgt_we = 1'b1;
                        REQ_QUERY: begin
                            o_cmd.query_load = 1'b1;
                            n_bad   = 1'b0;
                            n_state = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (!i_stat.basic_ok) begin
                    n_bad   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_sel  = DIV_IC;
                    n_state        = ST_DIV_IC;
                end
            end
            ST_DIV_IC: begin
                if (i_stat.div_done) begin
                    if (!i_stat.div_rem_zero) begin
                        n_bad   = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.cap_icg  = 1'b1;
                        o_cmd.div_load = 1'b1;
                        o_cmd.div_sel  = DIV_OC;
                        n_state        = ST_DIV_OC;
                    end
                end
            end
            ST_DIV_OC: begin
                if (i_stat.div_done) begin
                    if (!i_stat.div_rem_zero) begin
                        n_bad   = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        // channels per output group feed the group divide
                        o_cmd.div_load = 1'b1;
                        o_cmd.div_sel  = DIV_G;
                        n_state        = ST_DIV_G;
                    end
                end
            end
            ST_DIV_G: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_g = 1'b1;
                    n_state     = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_r        = '0;
                n_s        = '0;
                n_c        = '0;
                n_drain    = 1'b0;
                if (i_stat.kh == 3'd0 || i_stat.kw == 3'd0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_LOOP: begin
                o_cmd.tap = 1'b1;
                if (o_cmd.c_last) begin
                    n_c = '0;
                    if (r_s == i_stat.kw - 3'd1) begin
                        n_s = '0;
                        if (r_r == i_stat.kh - 3'd1) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_r = r_r + 3'd1;
                        end
                    end else begin
                        n_s = r_s + 3'd1;
                    end
                end else begin
                    n_c = r_c + 5'd1;
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_bad  = r_bad;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/gcsp_dp.sv
module gcsp_dp import gcsp_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_KERNEL   = MAX_KERNEL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [5:0]         i_cfg_data,
    input  logic [13:0]        i_mem_addr,
    input  logic signed [15:0] i_load_value,
    input  logic [3:0]         i_query_channel,
    input  logic [4:0]         i_query_row,
    input  logic [4:0]         i_query_col,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic signed [31:0] o_conv_sum,
    output logic               o_saturated,
    output logic               o_bad_query
);

    localparam int ACT_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int ACC_W = 33 + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1);

    // configuration
    logic [4:0] r_in_ch, r_out_ch, r_groups;
    logic [5:0] r_img_h, r_img_w;
    logic [2:0] r_kern_h, r_kern_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= 5'd1;
            r_out_ch <= 5'd1;
            r_groups <= 5'd1;
            r_img_h  <= 6'd32;
            r_img_w  <= 6'd32;
            r_kern_h <= 3'd3;
            r_kern_w <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_CH:  r_in_ch  <= i_cfg_data[4:0];
                CFG_OUT_CH: r_out_ch <= i_cfg_data[4:0];
                CFG_GROUPS: r_groups <= i_cfg_data[4:0];
                CFG_IMG_H:  r_img_h  <= i_cfg_data;
                CFG_IMG_W:  r_img_w  <= i_cfg_data;
                CFG_KERN_H: r_kern_h <= i_cfg_data[2:0];
                CFG_KERN_W: r_kern_w <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // query
    logic [3:0] r_qc;
    logic [4:0] r_qr, r_qx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_load) begin
            r_qc <= i_query_channel;
            r_qr <= i_query_row;
            r_qx <= i_query_col;
        end
    end

    assign o_stat.basic_ok =
        (r_groups != 5'd0) && (32'(r_groups) <= 32'(MAX_CHANNELS)) &&
        (r_in_ch != 5'd0) && (32'(r_in_ch) <= 32'(MAX_CHANNELS)) &&
        (r_out_ch != 5'd0) && (32'(r_out_ch) <= 32'(MAX_CHANNELS)) &&
        (r_img_h != 6'd0) && (32'(r_img_h) <= 32'(MAX_DIM)) &&
        (r_img_w != 6'd0) && (32'(r_img_w) <= 32'(MAX_DIM)) &&
        (32'(r_kern_h) <= 32'(MAX_KERNEL)) && (32'(r_kern_w) <= 32'(MAX_KERNEL)) &&
        ({1'b0, r_qc} < r_out_ch) && ({1'b0, r_qr} < r_img_h) &&
        ({1'b0, r_qx} < r_img_w);

    // divide by repeated subtraction, one step a cycle
    logic [4:0] r_num, r_den, r_quo, r_icg, r_grp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= '0;
            case (i_cmd.div_sel)
                DIV_IC: begin
                    r_num <= r_in_ch;
                    r_den <= r_groups;
                end
                DIV_OC: begin
                    r_num <= r_out_ch;
                    r_den <= r_groups;
                end
                DIV_G: begin
                    r_num <= {1'b0, r_qc};
                    r_den <= r_quo;
                end
                default: begin
                    r_num <= '0;
                    r_den <= 5'd1;
                end
            endcase
        end else if (r_num >= r_den) begin
            r_num <= r_num - r_den;
            r_quo <= r_quo + 5'd1;
        end
        if (i_cmd.cap_icg) r_icg <= r_quo;
        if (i_cmd.cap_g)   r_grp <= r_quo;
    end

    assign o_stat.div_done     = (r_num < r_den);
    assign o_stat.div_rem_zero = (r_num == 5'd0);
    assign o_stat.icg          = r_icg;
    assign o_stat.kh           = r_kern_h;
    assign o_stat.kw           = r_kern_w;

    // base products
    logic [11:0]    r_hw;
    logic [5:0]     r_kk;
    logic [9:0]     r_gi, r_oi;
    logic [AAW-1:0] r_abase, r_aoff;
    logic [WAW-1:0] r_wbase, r_woff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_hw <= r_img_h * r_img_w;
            r_kk <= r_kern_h * r_kern_w;
            r_gi <= r_grp * r_icg;
            r_oi <= {1'b0, r_qc} * r_icg;
        end
        if (i_cmd.mul2) begin
            r_abase <= AAW'(r_gi * r_hw);
            r_wbase <= WAW'(r_oi * r_kk);
            r_aoff  <= '0;
            r_woff  <= '0;
        end else if (i_cmd.tap) begin
            r_aoff <= i_cmd.c_last ? '0 : r_aoff + AAW'(r_hw);
            r_woff <= i_cmd.c_last ? '0 : r_woff + WAW'(r_kk);
        end
    end

    // tap position and addresses
    logic [2:0]        padh, padw;
    logic signed [7:0] tap_h, tap_w;
    logic              tap_in;
    logic [AAW-1:0]    a_addr;
    logic [WAW-1:0]    w_addr;

    always_comb begin
        padh   = (r_kern_h == 3'd0) ? 3'd0 : (r_kern_h - 3'd1) >> 1;
        padw   = (r_kern_w == 3'd0) ? 3'd0 : (r_kern_w - 3'd1) >> 1;
        tap_h  = $signed({3'b0, r_qr}) + $signed({5'b0, i_cmd.r}) - $signed({5'b0, padh});
        tap_w  = $signed({3'b0, r_qx}) + $signed({5'b0, i_cmd.s}) - $signed({5'b0, padw});
        tap_in = !tap_h[7] && (tap_h[6:0] < {1'b0, r_img_h}) &&
                 !tap_w[7] && (tap_w[6:0] < {1'b0, r_img_w});
        a_addr = r_abase + r_aoff + AAW'(tap_h[5:0] * r_img_w) + AAW'(tap_w[5:0]);
        w_addr = r_wbase + r_woff + WAW'(i_cmd.r * r_kern_w) + WAW'(i_cmd.s);
    end

    // memories
    logic signed [15:0] act_mem [ACT_DEPTH];
    logic signed [15:0] wgt_mem [WGT_DEPTH];
    logic signed [15:0] r_act_q, r_wgt_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_we && (32'(i_mem_addr) < 32'(ACT_DEPTH))) begin
            act_mem[AAW'(i_mem_addr)] <= i_load_value;
        end
        r_act_q <= act_mem[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt_we && (32'(i_mem_addr) < 32'(WGT_DEPTH))) begin
            wgt_mem[WAW'(i_mem_addr)] <= i_load_value;
        end
        r_wgt_q <= wgt_mem[w_addr];
    end

    // multiply-accumulate pipeline
    logic                    r_v1, r_v2;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap & tap_in;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_act_q * r_wgt_q;
        if (i_cmd.mul2) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // saturation and output word
    logic [ACC_W-32:0] acc_top;
    logic              acc_sat;
    logic signed [31:0] r_out_sum;
    logic              r_out_sat, r_out_bad;

    assign acc_top = r_acc[ACC_W-1:31];
    assign acc_sat = !((&acc_top) || !(|acc_top));

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_bad <= i_cmd.out_bad;
            if (i_cmd.out_bad) begin
                r_out_sum <= '0;
                r_out_sat <= 1'b0;
            end else if (acc_sat) begin
                r_out_sum <= r_acc[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                r_out_sat <= 1'b1;
            end else begin
                r_out_sum <= r_acc[31:0];
                r_out_sat <= 1'b0;
            end
        end
    end

    assign o_conv_sum  = r_out_sum;
    assign o_saturated = r_out_sat;
    assign o_bad_query = r_out_bad;

endmodule

### rtl/grouped_conv2d_same_pad_top.sv
// grouped 2d convolution, stride 1, same zero padding, q8.8 data and q16.16 results.
// load words (activation or weight) are taken one per cycle while idle and give no result.
// a query word walks the kernel window and the group's input channels with one
// multiply-accumulate per cycle, after a setup of three divides by repeated subtraction
// and two product steps, and ends with a pipeline drain. taps outside the image are
// stepped over but add nothing. a finished result sits in an output register so the
// next word can be taken while it waits; the memories need no clearing pass after reset.
module grouped_conv2d_same_pad_top import gcsp_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int MAX_KERNEL   = MAX_KERNEL_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [13:0]        i_mem_addr,
    input  logic signed [15:0] i_load_value,
    input  logic [3:0]         i_query_channel,
    input  logic [4:0]         i_query_row,
    input  logic [4:0]         i_query_col,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_conv_sum,
    output logic               o_saturated,
    output logic               o_bad_query,
    // register writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [5:0]         i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: handshakes, divides, tap loop, drain
    gcsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // registers, memories, address generation and mac
    gcsp_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_DIM      (MAX_DIM),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_mem_addr      (i_mem_addr),
        .i_load_value    (i_load_value),
        .i_query_channel (i_query_channel),
        .i_query_row     (i_query_row),
        .i_query_col     (i_query_col),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_conv_sum      (o_conv_sum),
        .o_saturated     (o_saturated),
        .o_bad_query     (o_bad_query)
    );

    // a rejected query carries a zero sum and no clip flag
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_query |-> (o_conv_sum == 32'sd0) && !o_saturated)
        else $error("bad query with nonzero result");

    // a clipped sum sits at one of the two rails
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_conv_sum == 32'sh7fff_ffff) || (o_conv_sum == 32'sh8000_0000))
        else $error("saturated result off the rails");

    // a result is only raised by finishing a query, which needs the input side busy
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a query in flight");

endmodule
